### rtl/vmp_pkg.sv
package vmp_pkg;

  typedef enum logic [3:0] {
    PH_VERSION     = 4'd0,
    PH_SERVICES    = 4'd1,
    PH_TIME        = 4'd2,
    PH_ADDR_RECV   = 4'd3,
    PH_SENDER_ADDR = 4'd4,
    PH_NONCE       = 4'd5,
    PH_PREFIX      = 4'd6,
    PH_LEN16       = 4'd7,
    PH_LEN32       = 4'd8,
    PH_AGENT       = 4'd9,
    PH_HEIGHT      = 4'd10,
    PH_DONE        = 4'd11
  } phase_t;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0]  PREFIX_LEN16 = 8'hFD;
  localparam logic [7:0]  PREFIX_LEN32 = 8'hFE;
  localparam logic [31:0] MIN_SENDER_ADDR_VERSION = 32'd106;

  localparam logic [4:0] INT32_BYTES = 5'd4;
  localparam logic [4:0] INT64_BYTES = 5'd8;
  localparam logic [4:0] ADDR_BYTES  = 5'd26;
  localparam logic [4:0] LEN16_BYTES = 5'd2;
  localparam logic [4:0] LEN32_BYTES = 5'd4;

  localparam logic KIND_AGENT   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_TRUNC = 1'b1;

  // One queue entry: what one accepted byte asks the output side to send.
  typedef struct packed {
    logic        has_agent;
    logic [7:0]  agent_byte;
    logic        has_summary;
    logic        status;
    logic [31:0] version;
    logic [31:0] height;
    logic [31:0] agent_length;
  } cmd_t;

  // Merge a byte into its little-endian lane.
  function automatic logic [31:0] insert_byte(input logic [31:0] value,
                                              input logic [7:0]  b,
                                              input logic [1:0]  lane);
    logic [31:0] r;
    r = value;
    case (lane)
      2'd0:    r[7:0]   = value[7:0]   | b;
      2'd1:    r[15:8]  = value[15:8]  | b;
      2'd2:    r[23:16] = value[23:16] | b;
      default: r[31:24] = value[31:24] | b;
    endcase
    return r;
  endfunction

endpackage

### rtl/vmp_in_if.sv
interface vmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;

  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink (input valid, input payload_byte, input last_byte, output ready);
endinterface

### rtl/vmp_out_if.sv
interface vmp_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         agent_byte;
  logic               status;
  logic signed [31:0] remote_version;
  logic signed [31:0] remote_height;
  logic [31:0]        agent_length;
  logic               run_end;

  modport source (output valid, output kind, output agent_byte, output status,
                  output remote_version, output remote_height, output agent_length,
                  output run_end, input ready);
  modport sink (input valid, input kind, input agent_byte, input status,
                input remote_version, input remote_height, input agent_length,
                input run_end, output ready);
endinterface

### rtl/vmp_front.sv
module vmp_front (
  input  logic           clk,
  input  logic           rst,
  vmp_in_if.sink         bytes,
  input  logic           queue_full,
  output logic           push,
  output vmp_pkg::cmd_t  cmd
);

  vmp_pkg::phase_t phase, phase_upd;
  logic [4:0]      count, count_upd, count_inc;
  logic [31:0]     remain, remain_upd;
  logic [31:0]     version, version_upd;
  logic [31:0]     height, height_upd;
  logic [31:0]     alen, alen_upd;
  logic            accept;
  logic [7:0]      b;

  assign bytes.ready = !queue_full;
  assign accept      = bytes.valid && bytes.ready;
  assign b           = bytes.payload_byte;
  assign count_inc   = count + 5'd1;

  // Next state
  always_comb begin
    phase_upd   = phase;
    count_upd   = count;
    remain_upd  = remain;
    version_upd = version;
    height_upd  = height;
    alen_upd    = alen;
    case (phase)
      vmp_pkg::PH_VERSION: begin
        version_upd = vmp_pkg::insert_byte(version, b, count[1:0]);
        count_upd   = count_inc;
        if (count_inc >= vmp_pkg::INT32_BYTES) begin
          phase_upd = vmp_pkg::PH_SERVICES;
          count_upd = '0;
        end
      end
      vmp_pkg::PH_SERVICES: begin
        count_upd = count_inc;
        if (count_inc >= vmp_pkg::INT64_BYTES) begin
          phase_upd = vmp_pkg::PH_TIME;
          count_upd = '0;
        end
      end
      vmp_pkg::PH_TIME: begin
        count_upd = count_inc;
        if (count_inc >= vmp_pkg::INT64_BYTES) begin
          phase_upd = vmp_pkg::PH_ADDR_RECV;
          count_upd = '0;
        end
      end
      vmp_pkg::PH_ADDR_RECV: begin
        count_upd = count_inc;
        if (count_inc >= vmp_pkg::ADDR_BYTES) begin
          count_upd = '0;
          // the sender address is present only for non-negative versions of 106 and up
          if (!version[31] && version >= vmp_pkg::MIN_SENDER_ADDR_VERSION) begin
            phase_upd = vmp_pkg::PH_SENDER_ADDR;
          end else begin
            phase_upd = vmp_pkg::PH_NONCE;
          end
        end
      end
      vmp_pkg::PH_SENDER_ADDR: begin
        count_upd = count_inc;
        if (count_inc >= vmp_pkg::ADDR_BYTES) begin
          phase_upd = vmp_pkg::PH_NONCE;
          count_upd = '0;
        end
      end
      vmp_pkg::PH_NONCE: begin
        count_upd = count_inc;
        if (count_inc >= vmp_pkg::INT64_BYTES) begin
          phase_upd = vmp_pkg::PH_PREFIX;
          count_upd = '0;
        end
      end
      vmp_pkg::PH_PREFIX: begin
        count_upd = '0;
        alen_upd  = '0;
        if (b == vmp_pkg::PREFIX_LEN16) begin
          phase_upd = vmp_pkg::PH_LEN16;
        end else if (b == vmp_pkg::PREFIX_LEN32) begin
          phase_upd = vmp_pkg::PH_LEN32;
        end else begin
          // any other byte, 0xFF included, is the length itself
          alen_upd   = {24'd0, b};
          remain_upd = {24'd0, b};
          phase_upd  = (b == 8'd0) ? vmp_pkg::PH_HEIGHT : vmp_pkg::PH_AGENT;
        end
      end
      vmp_pkg::PH_LEN16, vmp_pkg::PH_LEN32: begin
        alen_upd  = vmp_pkg::insert_byte(alen, b, count[1:0]);
        count_upd = count_inc;
        if (count_inc >= ((phase == vmp_pkg::PH_LEN16) ? vmp_pkg::LEN16_BYTES
                                                       : vmp_pkg::LEN32_BYTES)) begin
          remain_upd = alen_upd;
          count_upd  = '0;
          phase_upd  = (alen_upd == 32'd0) ? vmp_pkg::PH_HEIGHT : vmp_pkg::PH_AGENT;
        end
      end
      vmp_pkg::PH_AGENT: begin
        remain_upd = remain - 32'd1;
        if (remain_upd == 32'd0) begin
          phase_upd = vmp_pkg::PH_HEIGHT;
          count_upd = '0;
        end
      end
      vmp_pkg::PH_HEIGHT: begin
        height_upd = vmp_pkg::insert_byte(height, b, count[1:0]);
        count_upd  = count_inc;
        if (count_inc >= vmp_pkg::INT32_BYTES) begin
          phase_upd = vmp_pkg::PH_DONE;
          count_upd = '0;
        end
      end
      default: ;
    endcase
  end

  // Outputs: summary reflects the state after this word
  always_comb begin
    cmd.has_agent    = (phase == vmp_pkg::PH_AGENT);
    cmd.agent_byte   = b;
    cmd.has_summary  = bytes.last_byte;
    cmd.status       = (phase_upd == vmp_pkg::PH_DONE) ? vmp_pkg::STATUS_OK
                                                       : vmp_pkg::STATUS_TRUNC;
    cmd.version      = version_upd;
    cmd.height       = height_upd;
    cmd.agent_length = alen_upd;
    push             = accept && (cmd.has_agent || bytes.last_byte);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && bytes.last_byte)) begin
      phase   <= vmp_pkg::PH_VERSION;
      count   <= '0;
      remain  <= '0;
      version <= '0;
      height  <= '0;
      alen    <= '0;
    end else if (accept) begin
      phase   <= phase_upd;
      count   <= count_upd;
      remain  <= remain_upd;
      version <= version_upd;
      height  <= height_upd;
      alen    <= alen_upd;
    end
  end

endmodule

### rtl/vmp_queue.sv
module vmp_queue #(
  parameter int unsigned DEPTH = vmp_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vmp_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output vmp_pkg::cmd_t head_cmd
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_PTR   = PW'(DEPTH - 1);

  vmp_pkg::cmd_t entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_COUNT);
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/vmp_back.sv
module vmp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  vmp_pkg::cmd_t head_cmd,
  output logic          pop,
  vmp_out_if.source     results
);

  logic load, take, send_agent, sent_agent;

  always_comb begin
    load       = !results.valid || results.ready;
    take       = load && head_valid;
    send_agent = head_cmd.has_agent && !sent_agent;
    // hold the entry while its summary still has to follow the agent word
    pop        = take && !(send_agent && head_cmd.has_summary);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
      sent_agent    <= 1'b0;
    end else begin
      if (load) begin
        results.valid <= head_valid;
      end
      if (take) begin
        sent_agent <= send_agent && head_cmd.has_summary;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (send_agent) begin
        results.kind           <= vmp_pkg::KIND_AGENT;
        results.agent_byte     <= head_cmd.agent_byte;
        results.status         <= vmp_pkg::STATUS_OK;
        results.remote_version <= '0;
        results.remote_height  <= '0;
        results.agent_length   <= '0;
        results.run_end        <= !head_cmd.has_summary;
      end else begin
        results.kind           <= vmp_pkg::KIND_SUMMARY;
        results.agent_byte     <= '0;
        results.status         <= head_cmd.status;
        results.remote_version <= head_cmd.version;
        results.remote_height  <= head_cmd.height;
        results.agent_length   <= head_cmd.agent_length;
        results.run_end        <= 1'b1;
      end
    end
  end

endmodule

### rtl/version_message_parser_unit.sv
// Peer version payload parser.
// Input channel "bytes": one payload byte per word, last_byte marks the final
// byte of a payload. Output channel "results": one word per user-agent byte
// (kind 0), then one summary word (kind 1) on the last byte carrying status,
// version, start height and decoded agent length. run_end marks the last word
// caused by one input byte.
// Throughput: one byte per cycle while the queue is not full. A last byte that
// is also an agent byte makes two output words, and its queue entry is held
// until the second one is loaded. With an empty queue and a free output
// register, an accepted byte is written into the queue and then loaded from
// there into the output register, which raises results.valid.
// The front end and the output stage are parted by a QUEUE_DEPTH-entry queue;
// bytes.ready drops only when that queue is full, so a stalled receiver
// backs up the queue first and then the input.
// Reset clears the parser to the version field, empties the queue and drops
// results.valid. After each last byte the parser rearms by itself; bytes
// after the start height are ignored until last_byte.
module version_message_parser_unit #(
  parameter int unsigned QUEUE_DEPTH = vmp_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  vmp_in_if.sink    bytes,
  vmp_out_if.source results
);

  logic          push, pop, full, head_valid;
  vmp_pkg::cmd_t push_cmd, head_cmd;

  vmp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .queue_full (full),
    .push       (push),
    .cmd        (push_cmd)
  );

  vmp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  vmp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .results    (results)
  );

endmodule

### bench/testbench.sv
module testbench;

  localparam int IDLE_LIMIT  = 2000;
  localparam int ITEM_TARGET = 700;
  localparam int CALM_AFTER  = 600;
  localparam int REPORT_MAX  = 10;
  localparam int DIRECTED_N  = 9;

  typedef struct packed {
    logic        kind;
    logic [7:0]  agent_byte;
    logic        status;
    logic [31:0] version;
    logic [31:0] height;
    logic [31:0] agent_length;
    logic        run_end;
  } result_t;

  // One payload to send: field values, how to cut it short, and an optional
  // summary known in advance.
  typedef struct packed {
    logic [31:0] version;
    logic [7:0]  prefix;
    logic [31:0] alen;
    logic [31:0] height;
    logic [7:0]  trail;
    logic [7:0]  keep;
    logic [3:0]  drop;
    logic        fixed;
    logic        f_status;
    logic [31:0] f_version;
    logic [31:0] f_height;
    logic [31:0] f_length;
  } payload_t;

  logic clk = 1'b0;
  logic rst;

  vmp_in_if  byte_ch();
  vmp_out_if result_ch();

  version_message_parser_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (byte_ch),
    .results (result_ch)
  );

  always #5 clk = ~clk;

  // version, prefix, alen, height, trail, keep, drop, fixed, status, version, height, length
  payload_t directed_plan [DIRECTED_N] = '{
    '{32'h000000AB, 8'd0, 32'd0, 32'd0, 8'd0, 8'd1, 4'd0,
      1'b1, vmp_pkg::STATUS_TRUNC, 32'h000000AB, 32'd0, 32'd0},
    '{32'h12345678, 8'd0, 32'd0, 32'd0, 8'd0, 8'd2, 4'd0,
      1'b1, vmp_pkg::STATUS_TRUNC, 32'h00005678, 32'd0, 32'd0},
    '{32'h80000000, 8'd0, 32'd0, 32'h80000000, 8'd3, 8'd0, 4'd0,
      1'b1, vmp_pkg::STATUS_OK, 32'h80000000, 32'h80000000, 32'd0},
    '{32'd105, 8'd0, 32'd0, 32'h1234ABCD, 8'd0, 8'd0, 4'd2,
      1'b1, vmp_pkg::STATUS_TRUNC, 32'd105, 32'h0000ABCD, 32'd0},
    '{32'd106, 8'd2, 32'd0, 32'hFFFFFFFF, 8'd0, 8'd0, 4'd0,
      1'b1, vmp_pkg::STATUS_OK, 32'd106, 32'hFFFFFFFF, 32'd2},
    '{32'hFFFFFFFF, vmp_pkg::PREFIX_LEN16, 32'd5, 32'h00000001, 8'd0, 8'd0, 4'd0,
      1'b1, vmp_pkg::STATUS_OK, 32'hFFFFFFFF, 32'h00000001, 32'd5},
    '{32'd70015, 8'hFF, 32'd0, 32'h01020304, 8'd0, 8'd84, 4'd0,
      1'b1, vmp_pkg::STATUS_TRUNC, 32'd70015, 32'd0, 32'd255},
    '{32'h7FFFFFFF, vmp_pkg::PREFIX_LEN32, 32'hFFFFFFFF, 32'd0, 8'd0, 8'd88, 4'd0,
      1'b1, vmp_pkg::STATUS_TRUNC, 32'h7FFFFFFF, 32'd0, 32'hFFFFFFFF},
    '{32'd0, 8'd0, 32'd0, 32'h00000080, 8'd0, 8'd0, 4'd4,
      1'b0, vmp_pkg::STATUS_OK, 32'd0, 32'd0, 32'd0}
  };

  logic [7:0] frame_q[$];
  payload_t   pending_payloads[$];
  result_t    expected_q[$];
  int         mismatches  = 0;
  int         idle_cycles = 0;
  int         done_items  = 0;
  bit         calm        = 1'b0;

  // parser state as the block should hold it
  vmp_pkg::phase_t ph         = vmp_pkg::PH_VERSION;
  logic [4:0]      fcnt       = '0;
  logic [31:0]     agent_left = '0;
  logic [31:0]     ver_acc    = '0;
  logic [31:0]     hgt_acc    = '0;
  logic [31:0]     alen_acc   = '0;

  function automatic void count_field(input logic [4:0] span,
                                      input vmp_pkg::phase_t nxt);
    fcnt = fcnt + 5'd1;
    if (fcnt >= span) begin
      ph   = nxt;
      fcnt = '0;
    end
  endfunction

  function automatic void begin_agent();
    agent_left = alen_acc;
    ph         = (alen_acc == 32'd0) ? vmp_pkg::PH_HEIGHT : vmp_pkg::PH_AGENT;
    fcnt       = '0;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic last_flag,
                                     input payload_t plan);
    logic [31:0] lane_val;
    result_t     r;
    lane_val = {24'd0, b} << {fcnt[1:0], 3'b000};
    r        = '0;
    case (ph)
      vmp_pkg::PH_VERSION: begin
        ver_acc |= lane_val;
        count_field(vmp_pkg::INT32_BYTES, vmp_pkg::PH_SERVICES);
      end
      vmp_pkg::PH_SERVICES:  count_field(vmp_pkg::INT64_BYTES, vmp_pkg::PH_TIME);
      vmp_pkg::PH_TIME:      count_field(vmp_pkg::INT64_BYTES, vmp_pkg::PH_ADDR_RECV);
      // the sender address only follows for a signed version of 106 and up
      vmp_pkg::PH_ADDR_RECV:
        count_field(vmp_pkg::ADDR_BYTES,
                    ($signed(ver_acc) >= $signed(vmp_pkg::MIN_SENDER_ADDR_VERSION)) ?
                    vmp_pkg::PH_SENDER_ADDR : vmp_pkg::PH_NONCE);
      vmp_pkg::PH_SENDER_ADDR: count_field(vmp_pkg::ADDR_BYTES, vmp_pkg::PH_NONCE);
      vmp_pkg::PH_NONCE:       count_field(vmp_pkg::INT64_BYTES, vmp_pkg::PH_PREFIX);
      vmp_pkg::PH_PREFIX: begin
        alen_acc = '0;
        if (b == vmp_pkg::PREFIX_LEN16) begin
          ph   = vmp_pkg::PH_LEN16;
          fcnt = '0;
        end else if (b == vmp_pkg::PREFIX_LEN32) begin
          ph   = vmp_pkg::PH_LEN32;
          fcnt = '0;
        end else begin
          alen_acc = {24'd0, b};
          begin_agent();
        end
      end
      vmp_pkg::PH_LEN16, vmp_pkg::PH_LEN32: begin
        alen_acc |= lane_val;
        fcnt = fcnt + 5'd1;
        if (fcnt >= ((ph == vmp_pkg::PH_LEN16) ? vmp_pkg::LEN16_BYTES
                                                : vmp_pkg::LEN32_BYTES))
          begin_agent();
      end
      vmp_pkg::PH_AGENT: begin
        r.kind       = vmp_pkg::KIND_AGENT;
        r.agent_byte = b;
        r.run_end    = !last_flag;
        expected_q.push_back(r);
        agent_left = agent_left - 32'd1;
        if (agent_left == 32'd0) begin
          ph   = vmp_pkg::PH_HEIGHT;
          fcnt = '0;
        end
      end
      vmp_pkg::PH_HEIGHT: begin
        hgt_acc |= lane_val;
        count_field(vmp_pkg::INT32_BYTES, vmp_pkg::PH_DONE);
      end
      default: ;
    endcase
    if (last_flag) begin
      r.kind         = vmp_pkg::KIND_SUMMARY;
      r.agent_byte   = '0;
      r.status       = (ph == vmp_pkg::PH_DONE) ? vmp_pkg::STATUS_OK
                                                : vmp_pkg::STATUS_TRUNC;
      r.version      = ver_acc;
      r.height       = hgt_acc;
      r.agent_length = alen_acc;
      r.run_end      = 1'b1;
      if (plan.fixed) begin
        r.status       = plan.f_status;
        r.version      = plan.f_version;
        r.height       = plan.f_height;
        r.agent_length = plan.f_length;
      end
      expected_q.push_back(r);
      ph         = vmp_pkg::PH_VERSION;
      fcnt       = '0;
      agent_left = '0;
      ver_acc    = '0;
      hgt_acc    = '0;
      alen_acc   = '0;
    end
  endfunction

  task automatic report_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t %s: expected kind=%0d byte=%02h st=%0d ver=%08h hgt=%08h len=%08h end=%0d",
               $time, what, want.kind, want.agent_byte, want.status, want.version,
               want.height, want.agent_length, want.run_end,
               "\n    got      kind=%0d byte=%02h st=%0d ver=%08h hgt=%08h len=%08h end=%0d",
               got.kind, got.agent_byte, got.status, got.version, got.height,
               got.agent_length, got.run_end);
  endtask

  function automatic int pacing_odds();
    case ($urandom_range(2, 0))
      0:       return 0;
      1:       return 3;
      default: return 10;
    endcase
  endfunction

  task automatic put_le(input logic [31:0] value, input int count);
    for (int i = 0; i < count; i++)
      frame_q.push_back(value[8*i +: 8]);
  endtask

  task automatic put_noise(input int count);
    repeat (count) frame_q.push_back(8'($urandom));
  endtask

  task automatic build_payload(input payload_t m);
    logic [31:0] agent_count;
    int          limit;
    frame_q.delete();
    put_le(m.version, vmp_pkg::INT32_BYTES);
    put_noise(vmp_pkg::INT64_BYTES);
    put_noise(vmp_pkg::INT64_BYTES);
    put_noise(vmp_pkg::ADDR_BYTES);
    if ($signed(m.version) >= $signed(vmp_pkg::MIN_SENDER_ADDR_VERSION))
      put_noise(vmp_pkg::ADDR_BYTES);
    put_noise(vmp_pkg::INT64_BYTES);
    frame_q.push_back(m.prefix);
    if (m.prefix == vmp_pkg::PREFIX_LEN16) begin
      put_le(m.alen, vmp_pkg::LEN16_BYTES);
      agent_count = {16'd0, m.alen[15:0]};
    end else if (m.prefix == vmp_pkg::PREFIX_LEN32) begin
      put_le(m.alen, vmp_pkg::LEN32_BYTES);
      agent_count = m.alen;
    end else begin
      agent_count = {24'd0, m.prefix};
    end
    // stop huge agent strings at the cut point
    limit = (m.keep != 0) ? int'(m.keep) : (1 << 30);
    for (longint k = 0; k < agent_count && frame_q.size() < limit; k++)
      put_noise(1);
    put_le(m.height, vmp_pkg::INT32_BYTES);
    put_noise(m.trail);
    while (m.keep != 0 && frame_q.size() > int'(m.keep))
      void'(frame_q.pop_back());
    repeat (m.drop) void'(frame_q.pop_back());
  endtask

  task automatic send_frame(input payload_t m, input int gap_odds);
    pending_payloads.push_back(m);
    done_items += frame_q.size();
    foreach (frame_q[i]) begin
      if (gap_odds != 0 && !calm && $urandom_range(gap_odds - 1, 0) == 0) begin
        byte_ch.valid <= 1'b0;
        repeat ($urandom_range(14, 1)) @(posedge clk);
      end
      byte_ch.valid        <= 1'b1;
      byte_ch.payload_byte <= frame_q[i];
      byte_ch.last_byte    <= (i == frame_q.size() - 1);
      do @(posedge clk); while (!byte_ch.ready);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    result_t  got;
    result_t  want;
    payload_t plan;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got.kind         = result_ch.kind;
        got.agent_byte   = result_ch.agent_byte;
        got.status       = result_ch.status;
        got.version      = result_ch.remote_version;
        got.height       = result_ch.remote_height;
        got.agent_length = result_ch.agent_length;
        got.run_end      = result_ch.run_end;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want)
            report_mismatch("mismatch", want, got);
        end
      end
      if (byte_ch.valid && byte_ch.ready) begin
        plan = '0;
        if (byte_ch.last_byte && pending_payloads.size() != 0)
          plan = pending_payloads.pop_front();
        parse_byte(byte_ch.payload_byte, byte_ch.last_byte, plan);
      end
    end
  end

  // receiver: stall in bursts, rate changes now and then
  initial begin : result_pacing
    int stall_left;
    int stall_odds;
    stall_left      = 0;
    stall_odds      = 4;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(127, 0) == 0)
        stall_odds = pacing_odds();
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else if (!calm && stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0) begin
        stall_left      = $urandom_range(13, 0);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    payload_t m;
    int       trim;
    int       pick;
    rst                  = 1'b1;
    byte_ch.valid        = 1'b0;
    byte_ch.payload_byte = '0;
    byte_ch.last_byte    = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[r]) begin
      build_payload(directed_plan[r]);
      send_frame(directed_plan[r], pacing_odds());
    end

    // mostly well-formed payloads, some cut short, some plain noise
    while (done_items < ITEM_TARGET) begin
      calm = (done_items >= CALM_AFTER);
      m    = '0;
      if ($urandom_range(9, 0) == 0) begin
        frame_q.delete();
        put_noise($urandom_range(40, 1));
      end else begin
        case ($urandom_range(3, 0))
          0:       m.version = $urandom;
          1:       m.version = $urandom_range(112, 100);
          2:       m.version = 32'd70015;
          default: m.version = {1'b1, 31'($urandom)};
        endcase
        pick = $urandom_range(29, 0);
        if (pick == 0) begin
          m.prefix = 8'hFF;
        end else if (pick <= 6) begin
          m.prefix = vmp_pkg::PREFIX_LEN16;
          m.alen   = $urandom_range(6, 0);
        end else if (pick <= 12) begin
          m.prefix = vmp_pkg::PREFIX_LEN32;
          m.alen   = $urandom_range(6, 0);
        end else begin
          m.prefix = 8'($urandom_range(8, 0));
        end
        m.height = $urandom;
        if ($urandom_range(3, 0) == 0)
          m.trail = 8'($urandom_range(6, 1));
        build_payload(m);
        if ($urandom_range(3, 0) == 0) begin
          trim = $urandom_range(frame_q.size() - 1, 1);
          repeat (trim) void'(frame_q.pop_back());
        end
      end
      send_frame(m, pacing_odds());
    end

    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### sim.f
rtl/vmp_pkg.sv
rtl/vmp_in_if.sv
rtl/vmp_out_if.sv
rtl/vmp_front.sv
rtl/vmp_queue.sv
rtl/vmp_back.sv
rtl/version_message_parser_unit.sv
bench/testbench.sv
